[hw/rtl/ncs_pkg.sv]
// Package for the NAND command sequencer: geometry constants, NAND command
// bytes, bus-cycle kinds, status codes, run kinds and the result word struct.
// No dependencies.
`timescale 1ns / 1ps

package ncs_pkg;

  // Device geometry
  localparam int unsigned DEVICE_BYTES    = 134217728;
  localparam int unsigned PAGE_BYTES      = 2048;
  localparam int unsigned SPARE_BYTES     = 64;
  localparam int unsigned PAGES_PER_BLOCK = 64;

  localparam int unsigned BLOCK_BYTES = PAGE_BYTES * PAGES_PER_BLOCK;

  localparam logic [31:0] PAGE_MASK   = ~(32'(PAGE_BYTES) - 32'd1);
  localparam logic [31:0] BLOCK_MASK  = ~(32'(BLOCK_BYTES) - 32'd1);
  localparam logic [31:0] PAGE_OFFSET = 32'(PAGE_BYTES);

  // Flash window spans twice the device size above the base address
  localparam logic [32:0] WINDOW_BYTES = 33'(64'(DEVICE_BYTES) * 64'd2);

  localparam logic [9:0] PAGE_WORDS  = 10'(PAGE_BYTES / 4);
  localparam logic [9:0] SPARE_WORDS = 10'(SPARE_BYTES / 4);

  // Copy-back source and destination must sit in the same plane
  localparam int unsigned PLANE_BIT = 24;

  localparam int unsigned STEP_W = 5;

  // NAND command bytes
  localparam logic [7:0] CMD_READ     = 8'h00;
  localparam logic [7:0] CMD_READ_GO  = 8'h30;
  localparam logic [7:0] CMD_PROG     = 8'h80;
  localparam logic [7:0] CMD_PROG_GO  = 8'h10;
  localparam logic [7:0] CMD_COPY_RD  = 8'h35;
  localparam logic [7:0] CMD_COPY_WR  = 8'h85;
  localparam logic [7:0] CMD_ERASE    = 8'h60;
  localparam logic [7:0] CMD_ERASE_GO = 8'hD0;

  localparam logic [7:0] FILL_BYTE     = 8'hFF;
  localparam logic [7:0] BAD_MARK_BYTE = 8'h00;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_SPARE  = 3'd1,
    OP_WRITE  = 3'd2,
    OP_ERASE  = 3'd3,
    OP_COPY   = 3'd4,
    OP_MARK   = 3'd5,
    OP_STATUS = 3'd6,
    OP_UNUSED = 3'd7
  } ncs_op_t;

  typedef enum logic [3:0] {
    K_CE_ON     = 4'd0,
    K_CE_OFF    = 4'd1,
    K_WP_OFF    = 4'd2,
    K_WP_ON     = 4'd3,
    K_CMD       = 4'd4,
    K_ADDR      = 4'd5,
    K_DATA      = 4'd6,
    K_WAIT      = 4'd7,
    K_RD        = 4'd8,
    K_WR        = 4'd9,
    K_ECC_START = 4'd10,
    K_ECC_STOP  = 4'd11,
    K_ECC_WRITE = 4'd12,
    K_STATUS    = 4'd13,
    K_DONE      = 4'd14
  } ncs_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINIT  = 2'd1,
    ST_BADADDR = 2'd2,
    ST_WRERR   = 2'd3
  } ncs_status_t;

  typedef enum logic [3:0] {
    RUN_NONE,
    RUN_NOINIT,
    RUN_BADADDR,
    RUN_READ,
    RUN_SPARE,
    RUN_WRITE,
    RUN_ERASE,
    RUN_COPY,
    RUN_MARK,
    RUN_STATUS
  } ncs_run_t;

  typedef struct packed {
    ncs_kind_t   kind;
    logic [7:0]  data;
    logic [9:0]  words;
    ncs_status_t code;
    logic        last;
  } ncs_word_t;

endpackage

[hw/rtl/ncs_check.sv]
// Request check: aligns the addresses, tests them against the flash window
// and picks the bus-cycle run for the request. Depends on ncs_pkg.
`timescale 1ns / 1ps

module ncs_check (
  input  logic [2:0]       opcode,
  input  logic [31:0]      address,
  input  logic [31:0]      src_address,
  input  logic [31:0]      base_address,
  input  logic [32:0]      window_end,
  input  logic             initialized,
  input  logic             awaiting,
  output ncs_pkg::ncs_run_t run,
  output logic [31:0]      dst_aligned,
  output logic [31:0]      src_aligned,
  output logic             awaiting_next
);
  import ncs_pkg::*;

  logic [31:0] page_a;
  logic [31:0] blk_a;
  logic [31:0] base_sel;
  logic        add_page;
  logic        dst_ok;
  logic        src_ok;
  logic        plane_ok;
  logic        addr_ok;
  ncs_op_t     op;

  function automatic logic in_window(input logic [31:0] x, input logic [31:0] lo,
                                     input logic [32:0] hi);
    in_window = (x >= lo) && ({1'b0, x} < hi);
  endfunction

  assign op     = ncs_op_t'(opcode);
  assign page_a = address & PAGE_MASK;
  assign blk_a  = address & BLOCK_MASK;
  assign src_aligned = src_address & PAGE_MASK;

  always_comb begin
    case (op)
      OP_SPARE: begin
        base_sel = page_a;
        add_page = 1'b1;
      end
      OP_ERASE: begin
        base_sel = blk_a;
        add_page = 1'b0;
      end
      OP_MARK: begin
        base_sel = blk_a;
        add_page = 1'b1;
      end
      default: begin
        base_sel = page_a;
        add_page = 1'b0;
      end
    endcase
  end

  // spare area sits one page above the aligned address, wrapping at 32 bits
  assign dst_aligned = add_page ? base_sel + PAGE_OFFSET : base_sel;

  assign dst_ok   = in_window(dst_aligned, base_address, window_end);
  assign src_ok   = in_window(src_aligned, base_address, window_end);
  assign plane_ok = page_a[PLANE_BIT] == src_aligned[PLANE_BIT];
  assign addr_ok  = dst_ok && ((op != OP_COPY) || (src_ok && plane_ok));

  always_comb begin
    run           = RUN_NONE;
    awaiting_next = awaiting;
    if (op == OP_STATUS) begin
      if (awaiting) begin
        run           = RUN_STATUS;
        awaiting_next = 1'b0;
      end
    end else if (op != OP_UNUSED && !awaiting) begin
      if (!initialized) begin
        run = RUN_NOINIT;
      end else if (!addr_ok) begin
        run = RUN_BADADDR;
      end else begin
        case (op)
          OP_READ:  run = RUN_READ;
          OP_SPARE: run = RUN_SPARE;
          OP_WRITE: run = RUN_WRITE;
          OP_ERASE: run = RUN_ERASE;
          OP_COPY:  run = RUN_COPY;
          OP_MARK:  run = RUN_MARK;
          default:  run = RUN_NONE;
        endcase
        if (op == OP_WRITE || op == OP_ERASE || op == OP_COPY) begin
          awaiting_next = 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/ncs_step_gen.sv]
// Step table: gives the bus-cycle word for one step of a run, with the
// address bytes picked from the aligned addresses. Depends on ncs_pkg.
`timescale 1ns / 1ps

module ncs_step_gen (
  input  ncs_pkg::ncs_run_t  run,
  input  logic [4:0]         step,
  input  logic [31:0]        dst,
  input  logic [31:0]        src,
  input  logic               wr_err,
  output ncs_pkg::ncs_word_t word
);
  import ncs_pkg::*;

  function automatic ncs_word_t mk(input ncs_kind_t k, input logic [7:0] d,
                                   input logic [9:0] w, input ncs_status_t c,
                                   input logic l);
    ncs_word_t r;
    r.kind  = k;
    r.data  = d;
    r.words = w;
    r.code  = c;
    r.last  = l;
    mk = r;
  endfunction

  function automatic ncs_word_t plain(input ncs_kind_t k);
    plain = mk(k, 8'h00, 10'd0, ST_OK, 1'b0);
  endfunction

  function automatic ncs_word_t cmd(input logic [7:0] c);
    cmd = mk(K_CMD, c, 10'd0, ST_OK, 1'b0);
  endfunction

  // row/column address bytes; second column byte keeps only bits 11:8
  function automatic ncs_word_t addr(input logic [31:0] x, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = x[7:0];
      2'd1:    b = {4'b0000, x[11:8]};
      2'd2:    b = x[19:12];
      default: b = x[27:20];
    endcase
    addr = mk(K_ADDR, b, 10'd0, ST_OK, 1'b0);
  endfunction

  localparam ncs_word_t DONE_OK  = '{K_DONE, 8'h00, 10'd0, ST_OK, 1'b1};
  localparam ncs_word_t IDLE_W   = '{K_DONE, 8'h00, 10'd0, ST_OK, 1'b1};
  localparam ncs_word_t STATUS_L = '{K_STATUS, 8'h00, 10'd0, ST_OK, 1'b1};

  always_comb begin
    word = IDLE_W;
    case (run)
      RUN_READ: begin
        case (step) inside
          5'd0:           word = plain(K_CE_ON);
          5'd1:           word = cmd(CMD_READ);
          [5'd2:5'd5]:    word = addr(dst, 2'(step - 5'd2));
          5'd6:           word = cmd(CMD_READ_GO);
          5'd7:           word = plain(K_WAIT);
          5'd8:           word = plain(K_ECC_START);
          5'd9:           word = mk(K_RD, 8'h00, PAGE_WORDS, ST_OK, 1'b0);
          5'd10:          word = plain(K_ECC_STOP);
          5'd11:          word = mk(K_RD, 8'h00, SPARE_WORDS, ST_OK, 1'b0);
          5'd12:          word = plain(K_CE_OFF);
          default:        word = DONE_OK;
        endcase
      end
      RUN_SPARE: begin
        case (step) inside
          5'd0:           word = plain(K_CE_ON);
          5'd1:           word = cmd(CMD_READ);
          [5'd2:5'd5]:    word = addr(dst, 2'(step - 5'd2));
          5'd6:           word = cmd(CMD_READ_GO);
          5'd7:           word = plain(K_WAIT);
          5'd8:           word = mk(K_RD, 8'h00, SPARE_WORDS, ST_OK, 1'b0);
          5'd9:           word = plain(K_CE_OFF);
          default:        word = DONE_OK;
        endcase
      end
      RUN_WRITE: begin
        case (step) inside
          5'd0:           word = plain(K_WP_OFF);
          5'd1:           word = plain(K_CE_ON);
          5'd2:           word = cmd(CMD_PROG);
          [5'd3:5'd6]:    word = addr(dst, 2'(step - 5'd3));
          5'd7:           word = plain(K_ECC_START);
          5'd8:           word = mk(K_WR, 8'h00, PAGE_WORDS, ST_OK, 1'b0);
          5'd9:           word = plain(K_ECC_STOP);
          [5'd10:5'd15]:  word = mk(K_DATA, FILL_BYTE, 10'd0, ST_OK, 1'b0);
          [5'd16:5'd18]:  word = plain(K_ECC_WRITE);
          5'd19:          word = cmd(CMD_PROG_GO);
          5'd20:          word = plain(K_WAIT);
          default:        word = STATUS_L;
        endcase
      end
      RUN_ERASE: begin
        case (step) inside
          5'd0:           word = plain(K_WP_OFF);
          5'd1:           word = plain(K_CE_ON);
          5'd2:           word = cmd(CMD_ERASE);
          [5'd3:5'd4]:    word = addr(dst, 2'(step - 5'd1));
          5'd5:           word = cmd(CMD_ERASE_GO);
          5'd6:           word = plain(K_WAIT);
          default:        word = STATUS_L;
        endcase
      end
      RUN_COPY: begin
        case (step) inside
          5'd0:           word = plain(K_WP_OFF);
          5'd1:           word = plain(K_CE_ON);
          5'd2:           word = cmd(CMD_READ);
          [5'd3:5'd6]:    word = addr(src, 2'(step - 5'd3));
          5'd7:           word = cmd(CMD_COPY_RD);
          5'd8:           word = plain(K_WAIT);
          5'd9:           word = cmd(CMD_COPY_WR);
          [5'd10:5'd13]:  word = addr(dst, 2'(step - 5'd10));
          5'd14:          word = cmd(CMD_PROG_GO);
          5'd15:          word = plain(K_WAIT);
          default:        word = STATUS_L;
        endcase
      end
      RUN_MARK: begin
        case (step) inside
          5'd0:           word = plain(K_WP_OFF);
          5'd1:           word = plain(K_CE_ON);
          5'd2:           word = cmd(CMD_PROG);
          [5'd3:5'd6]:    word = addr(dst, 2'(step - 5'd3));
          5'd7:           word = mk(K_DATA, BAD_MARK_BYTE, 10'd0, ST_OK, 1'b0);
          5'd8:           word = cmd(CMD_PROG_GO);
          5'd9:           word = plain(K_WAIT);
          5'd10:          word = plain(K_STATUS);
          5'd11:          word = plain(K_CE_OFF);
          5'd12:          word = plain(K_WP_ON);
          default:        word = DONE_OK;
        endcase
      end
      RUN_STATUS: begin
        case (step) inside
          5'd0:    word = plain(K_CE_OFF);
          5'd1:    word = plain(K_WP_ON);
          default: word = mk(K_DONE, 8'h00, 10'd0, wr_err ? ST_WRERR : ST_OK, 1'b1);
        endcase
      end
      RUN_NOINIT:  word = mk(K_DONE, 8'h00, 10'd0, ST_NOINIT, 1'b1);
      RUN_BADADDR: word = mk(K_DONE, 8'h00, 10'd0, ST_BADADDR, 1'b1);
      default:     word = IDLE_W;
    endcase
  end

endmodule

[hw/rtl/nand_command_sequencer.sv]
// NAND command sequencer top: input register, request check, step sequencer
// and output register. Depends on ncs_pkg, ncs_check, ncs_step_gen.
// The first word of a run passes the input, sequencer and output registers.
// Throughput: one word per cycle while out_ready is high; a request holds the
// sequencer for its run length (1 to 22 words), ignored requests start no run.
// Reset (rst, synchronous): pipeline empty, no status pending, base zero, not initialized.
`timescale 1ns / 1ps

module nand_command_sequencer (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] address,
  input  logic [31:0] src_address,
  input  logic [7:0]  status_byte,
  // bus-cycle word channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  cycle_kind,
  output logic [7:0]  bus_byte,
  output logic [9:0]  burst_words,
  output logic [1:0]  status_code,
  output logic        last
);
  import ncs_pkg::*;

  // configuration registers; window_end tracks base_address + window size
  logic [31:0] base_address;
  logic        initialized;
  logic [32:0] window_end;

  // pending status report after program, erase or copy
  logic        awaiting_status;

  // input register
  logic        req_valid;
  logic [2:0]  req_op;
  logic [31:0] req_addr;
  logic [31:0] req_src;
  logic        req_err;

  // sequencer: one run at a time, one word per step
  logic        seq_valid;
  ncs_run_t    seq_run;
  logic [31:0] seq_dst;
  logic [31:0] seq_src;
  logic        seq_err;
  logic [STEP_W-1:0] seq_step;

  // output register
  ncs_word_t   out_word;

  ncs_run_t    dec_run;
  logic [31:0] dec_dst;
  logic [31:0] dec_src;
  logic        awaiting_next;
  ncs_word_t   step_word;

  logic        cfg_wr;
  logic        seq_adv;
  logic        seq_end;
  logic        req_take;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {31'b0, initialized} : base_address;

  ncs_check u_check (
    .opcode        (req_op),
    .address       (req_addr),
    .src_address   (req_src),
    .base_address  (base_address),
    .window_end    (window_end),
    .initialized   (initialized),
    .awaiting      (awaiting_status),
    .run           (dec_run),
    .dst_aligned   (dec_dst),
    .src_aligned   (dec_src),
    .awaiting_next (awaiting_next)
  );

  ncs_step_gen u_step (
    .run    (seq_run),
    .step   (seq_step),
    .dst    (seq_dst),
    .src    (seq_src),
    .wr_err (seq_err),
    .word   (step_word)
  );

  // Sequencer moves when the output register is empty or being drained.
  // A new request is decoded into the sequencer in the cycle its last word
  // leaves, so runs follow each other with no gap.
  assign seq_adv  = seq_valid && (!out_valid || out_ready);
  assign seq_end  = seq_adv && step_word.last;
  assign req_take = req_valid && (!seq_valid || seq_end);
  assign in_ready = !req_valid || req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= 32'd0;
      initialized     <= 1'b0;
      window_end      <= WINDOW_BYTES;
      awaiting_status <= 1'b0;
      req_valid       <= 1'b0;
      seq_valid       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2]) begin
          initialized <= pwdata[0];
        end else begin
          base_address <= pwdata;
          window_end   <= {1'b0, pwdata} + WINDOW_BYTES;
        end
      end

      if (in_valid && in_ready) begin
        req_valid <= 1'b1;
      end else if (req_take) begin
        req_valid <= 1'b0;
      end

      // status state follows each request as it is decoded, in order
      if (req_take) begin
        seq_valid       <= dec_run != RUN_NONE;
        awaiting_status <= awaiting_next;
      end else if (seq_end) begin
        seq_valid <= 1'b0;
      end

      if (seq_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op   <= opcode;
      req_addr <= address;
      req_src  <= src_address;
      req_err  <= status_byte[0];
    end
    if (req_take) begin
      seq_run  <= dec_run;
      seq_dst  <= dec_dst;
      seq_src  <= dec_src;
      seq_err  <= req_err;
      seq_step <= '0;
    end else if (seq_adv) begin
      seq_step <= seq_step + STEP_W'(1);
    end
    if (seq_adv) begin
      out_word <= step_word;
    end
  end

  assign cycle_kind  = out_word.kind;
  assign bus_byte    = out_word.data;
  assign burst_words = out_word.words;
  assign status_code = out_word.code;
  assign last        = out_word.last;

  // longest run is the page program, 22 words
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> seq_step < 5'd22)
    else $error("sequencer step beyond longest run");

  // while a status report is pending only the report itself starts a run
  a_hold_for_status: assert property (@(posedge clk) disable iff (rst)
    (req_take && awaiting_status) |-> (dec_run == RUN_STATUS || dec_run == RUN_NONE))
    else $error("run started while status pending");

  // runs that end in a status request leave the block waiting for the report
  a_status_armed: assert property (@(posedge clk) disable iff (rst)
    (req_take && (dec_run == RUN_WRITE || dec_run == RUN_ERASE ||
                  dec_run == RUN_COPY)) |=> awaiting_status)
    else $error("status wait not armed");

  // a run keeps the sequencer busy until its last word
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (seq_adv && !step_word.last) |=> seq_valid)
    else $error("run dropped before last word");

endmodule

[bench/nand_command_sequencer_test.sv]
// Self-checking bench for nand_command_sequencer: directed table, then random phases.
// Expected bus-cycle words come from a predictor in this file; depends on ncs_pkg.
`timescale 1ns / 1ps

module nand_command_sequencer_test;
  import ncs_pkg::*;

  // Register byte addresses on the config port
  localparam logic [2:0] REG_BASE_ADDR = 3'd0;
  localparam logic [2:0] REG_INIT_ADDR = 3'd4;

  // Geometry derived locally for the predictor
  localparam logic [31:0] PG_MASK  = ~(32'(PAGE_BYTES) - 32'd1);
  localparam logic [31:0] BLK_MASK = ~(32'(PAGE_BYTES * PAGES_PER_BLOCK) - 32'd1);
  localparam logic [31:0] WIN_SPAN = 32'(DEVICE_BYTES) * 32'd2;
  localparam logic [9:0]  PG_WORDS = 10'(PAGE_BYTES / 4);
  localparam logic [9:0]  SP_WORDS = 10'(SPARE_BYTES / 4);

  // Bus-cycle words trail the request through the input, sequencer and output registers; allow slack
  localparam int IDLE_PAUSE = 8;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One directed row: either a request or a register write.
  // typed = 1 means the expected word is the single done word with code.
  typedef struct {
    row_kind_t   kind;
    logic [2:0]  reg_addr;
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] s;
    logic [7:0]  sb;
    bit          typed;
    ncs_status_t code;
  } stim_row_t;

  typedef struct {
    bit          rand_base;
    logic [31:0] base;
    logic        init;
    int          count;
  } phase_t;

  localparam int N_ROWS = 29;

  stim_row_t directed_rows [0:N_ROWS-1] = '{
    // out of reset: not initialized, idle status report and unused opcode dropped
    '{ROW_REQ, REG_BASE_ADDR, OP_READ,   32'h0000_0000, 32'h0, 8'h00, 1'b1, ST_NOINIT},
    '{ROW_REQ, REG_BASE_ADDR, OP_STATUS, 32'h0000_0000, 32'h0, 8'hFF, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_UNUSED, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_CFG, REG_INIT_ADDR, OP_READ,   32'h0000_0001, 32'h0, 8'h00, 1'b0, ST_OK},
    // base 0: window edges
    '{ROW_REQ, REG_BASE_ADDR, OP_READ,   32'h0000_07FF, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_SPARE,  32'h0FFF_F7FF, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_SPARE,  32'h0FFF_F800, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    '{ROW_REQ, REG_BASE_ADDR, OP_READ,   32'h1000_0000, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    // program, then a request that is dropped while status is pending
    '{ROW_REQ, REG_BASE_ADDR, OP_WRITE,  32'h0FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_READ,   32'h0000_0000, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_STATUS, 32'hFFFF_FFFF, 32'h0, 8'hFE, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_ERASE,  32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    '{ROW_REQ, REG_BASE_ADDR, OP_ERASE,  32'h0ABC_DEF0, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_STATUS, 32'h0000_0000, 32'h0, 8'h01, 1'b0, ST_OK},
    // copy across planes is refused, within one plane it runs
    '{ROW_REQ, REG_BASE_ADDR, OP_COPY,   32'h0100_0800, 32'h0000_1000, 8'h00, 1'b1,
      ST_BADADDR},
    '{ROW_REQ, REG_BASE_ADDR, OP_COPY,   32'h01FF_F800, 32'h0100_0000, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_STATUS, 32'h0000_0000, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_MARK,   32'h0FFF_FFFF, 32'h0, 8'h01, 1'b0, ST_OK},
    // base at the top: nothing aligned can fall inside
    '{ROW_CFG, REG_BASE_ADDR, OP_READ,   32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_MARK,   32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    // window reaching up to 2^32; spare offset wraps to zero
    '{ROW_CFG, REG_BASE_ADDR, OP_READ,   32'hF000_0000, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_SPARE,  32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    '{ROW_REQ, REG_BASE_ADDR, OP_READ,   32'hFFFF_FFFF, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_READ,   32'h0000_0000, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    '{ROW_REQ, REG_BASE_ADDR, OP_COPY,   32'hFFFF_FFFF, 32'hF1FF_F800, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_STATUS, 32'h0000_0000, 32'h0, 8'h00, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_MARK,   32'hEFFF_FFFF, 32'h0, 8'h00, 1'b1, ST_BADADDR},
    // status report with nothing pending is dropped here too
    '{ROW_REQ, REG_BASE_ADDR, OP_STATUS, 32'h0000_0000, 32'h0, 8'h01, 1'b0, ST_OK},
    '{ROW_REQ, REG_BASE_ADDR, OP_WRITE,  32'hF000_0000, 32'h0, 8'h00, 1'b0, ST_OK}
  };

  // Register settings for the random part; one phase runs with the device
  // uninitialized so the rejection path sees random traffic as well.
  phase_t rand_phases [0:4] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 60},
    '{1'b1, 32'h0000_0000, 1'b1, 60},
    '{1'b0, 32'hF800_0000, 1'b1, 60},
    '{1'b0, 32'h0000_0000, 1'b0, 20},
    '{1'b0, 32'h3B40_0000, 1'b1, 60}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [2:0]  opcode;
  logic [31:0] address, src_address;
  logic [7:0]  status_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  cycle_kind;
  logic [7:0]  bus_byte;
  logic [9:0]  burst_words;
  logic [1:0]  status_code;
  logic        last;

  // Predictor state: register copies and the pending-status flag
  logic [31:0] cfg_base;
  logic        cfg_init;
  logic        exp_awaiting;

  ncs_word_t   pending_words [$];
  int          mismatch_count;
  int          burst_left;

  nand_command_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .address     (address),
    .src_address (src_address),
    .status_byte (status_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cycle_kind  (cycle_kind),
    .bus_byte    (bus_byte),
    .burst_words (burst_words),
    .status_code (status_code),
    .last        (last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_word(ncs_kind_t k, logic [7:0] d, logic [9:0] w,
                                    ncs_status_t c);
    ncs_word_t wd;
    wd.kind  = k;
    wd.data  = d;
    wd.words = w;
    wd.code  = c;
    wd.last  = 1'b0;
    pending_words.push_back(wd);
  endfunction

  // base <= a < base + 2*device size, without wrap (hence 33 bits)
  function automatic bit in_flash_window(logic [31:0] a);
    logic [32:0] lo;
    logic [32:0] hi;
    lo = {1'b0, cfg_base};
    hi = lo + {1'b0, WIN_SPAN};
    return ({1'b0, a} >= lo) && ({1'b0, a} < hi);
  endfunction

  // Full 4-byte page address: column low, column high nibble, row low, row high
  function automatic void push_page_addr(logic [31:0] a);
    push_word(K_ADDR, a[7:0], 10'd0, ST_OK);
    push_word(K_ADDR, {4'h0, a[11:8]}, 10'd0, ST_OK);
    push_word(K_ADDR, a[19:12], 10'd0, ST_OK);
    push_word(K_ADDR, a[27:20], 10'd0, ST_OK);
  endfunction

  // Expands one accepted request into the bus-cycle words it must produce
  function automatic void expand_request(logic [2:0] op, logic [31:0] a_in,
                                         logic [31:0] s_in, logic [7:0] sb);
    logic [31:0] a;
    logic [31:0] s;
    bit          ok;
    int          first;
    first = pending_words.size();
    a = a_in;
    s = s_in;
    ok = 1'b1;
    if (op == OP_UNUSED) return;
    if (op == OP_STATUS) begin
      if (!exp_awaiting) return;
      exp_awaiting = 1'b0;
      push_word(K_CE_OFF, 8'h00, 10'd0, ST_OK);
      push_word(K_WP_ON, 8'h00, 10'd0, ST_OK);
      push_word(K_DONE, 8'h00, 10'd0, sb[0] ? ST_WRERR : ST_OK);
    end else if (exp_awaiting) begin
      return;
    end else if (!cfg_init) begin
      push_word(K_DONE, 8'h00, 10'd0, ST_NOINIT);
    end else begin
      case (op)
        OP_READ, OP_WRITE: begin
          a = a & PG_MASK;
          ok = in_flash_window(a);
        end
        OP_SPARE: begin
          a = (a & PG_MASK) + 32'(PAGE_BYTES);
          ok = in_flash_window(a);
        end
        OP_ERASE: begin
          a = a & BLK_MASK;
          ok = in_flash_window(a);
        end
        OP_COPY: begin
          a = a & PG_MASK;
          s = s & PG_MASK;
          ok = in_flash_window(a) && in_flash_window(s) && (a[24] == s[24]);
        end
        default: begin
          // mark bad: spare area of the block's first page
          a = (a & BLK_MASK) + 32'(PAGE_BYTES);
          ok = in_flash_window(a);
        end
      endcase
      if (!ok) begin
        push_word(K_DONE, 8'h00, 10'd0, ST_BADADDR);
      end else begin
        case (op)
          OP_READ, OP_SPARE: begin
            push_word(K_CE_ON, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_READ, 10'd0, ST_OK);
            push_page_addr(a);
            push_word(K_CMD, CMD_READ_GO, 10'd0, ST_OK);
            push_word(K_WAIT, 8'h00, 10'd0, ST_OK);
            if (op == OP_READ) begin
              push_word(K_ECC_START, 8'h00, 10'd0, ST_OK);
              push_word(K_RD, 8'h00, PG_WORDS, ST_OK);
              push_word(K_ECC_STOP, 8'h00, 10'd0, ST_OK);
            end
            push_word(K_RD, 8'h00, SP_WORDS, ST_OK);
            push_word(K_CE_OFF, 8'h00, 10'd0, ST_OK);
            push_word(K_DONE, 8'h00, 10'd0, ST_OK);
          end
          OP_WRITE: begin
            push_word(K_WP_OFF, 8'h00, 10'd0, ST_OK);
            push_word(K_CE_ON, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_PROG, 10'd0, ST_OK);
            push_page_addr(a);
            push_word(K_ECC_START, 8'h00, 10'd0, ST_OK);
            push_word(K_WR, 8'h00, PG_WORDS, ST_OK);
            push_word(K_ECC_STOP, 8'h00, 10'd0, ST_OK);
            repeat (6) push_word(K_DATA, FILL_BYTE, 10'd0, ST_OK);
            repeat (3) push_word(K_ECC_WRITE, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_PROG_GO, 10'd0, ST_OK);
            push_word(K_WAIT, 8'h00, 10'd0, ST_OK);
            push_word(K_STATUS, 8'h00, 10'd0, ST_OK);
            exp_awaiting = 1'b1;
          end
          OP_ERASE: begin
            push_word(K_WP_OFF, 8'h00, 10'd0, ST_OK);
            push_word(K_CE_ON, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_ERASE, 10'd0, ST_OK);
            push_word(K_ADDR, a[19:12], 10'd0, ST_OK);
            push_word(K_ADDR, a[27:20], 10'd0, ST_OK);
            push_word(K_CMD, CMD_ERASE_GO, 10'd0, ST_OK);
            push_word(K_WAIT, 8'h00, 10'd0, ST_OK);
            push_word(K_STATUS, 8'h00, 10'd0, ST_OK);
            exp_awaiting = 1'b1;
          end
          OP_COPY: begin
            push_word(K_WP_OFF, 8'h00, 10'd0, ST_OK);
            push_word(K_CE_ON, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_READ, 10'd0, ST_OK);
            push_page_addr(s);
            push_word(K_CMD, CMD_COPY_RD, 10'd0, ST_OK);
            push_word(K_WAIT, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_COPY_WR, 10'd0, ST_OK);
            push_page_addr(a);
            push_word(K_CMD, CMD_PROG_GO, 10'd0, ST_OK);
            push_word(K_WAIT, 8'h00, 10'd0, ST_OK);
            push_word(K_STATUS, 8'h00, 10'd0, ST_OK);
            exp_awaiting = 1'b1;
          end
          default: begin
            // mark bad: status is requested but never evaluated
            push_word(K_WP_OFF, 8'h00, 10'd0, ST_OK);
            push_word(K_CE_ON, 8'h00, 10'd0, ST_OK);
            push_word(K_CMD, CMD_PROG, 10'd0, ST_OK);
            push_page_addr(a);
            push_word(K_DATA, BAD_MARK_BYTE, 10'd0, ST_OK);
            push_word(K_CMD, CMD_PROG_GO, 10'd0, ST_OK);
            push_word(K_WAIT, 8'h00, 10'd0, ST_OK);
            push_word(K_STATUS, 8'h00, 10'd0, ST_OK);
            push_word(K_CE_OFF, 8'h00, 10'd0, ST_OK);
            push_word(K_WP_ON, 8'h00, 10'd0, ST_OK);
            push_word(K_DONE, 8'h00, 10'd0, ST_OK);
          end
        endcase
      end
    end
    if (pending_words.size() > first)
      pending_words[pending_words.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all called at a falling edge)
  // ---------------------------------------------------------------------------

  // Offer one request, hold it until taken, then maybe open a gap
  task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] s,
                              logic [7:0] sb, bit typed, ncs_status_t code);
    in_valid    = 1'b1;
    opcode      = op;
    address     = a;
    src_address = s;
    status_byte = sb;
    do @(posedge clk); while (!in_ready);
    if (typed) begin
      push_word(K_DONE, 8'h00, 10'd0, code);
      pending_words[pending_words.size() - 1].last = 1'b1;
    end else begin
      expand_request(op, a, s, sb);
    end
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 11);
    end else begin
      burst_left--;
    end
  endtask

  // Block idle: nothing offered, every expected word seen, pipeline flushed
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (IDLE_PAUSE) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == REG_BASE_ADDR) cfg_base = data;
    else cfg_init = data[0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Mostly in-window addresses, some near both edges, some anywhere
  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 22) return cfg_base + WIN_SPAN - 32'($urandom_range(0, 4096));
    if (r < 26) return cfg_base - 32'($urandom_range(1, 4096));
    return cfg_base + 32'($urandom_range(0, WIN_SPAN - 1));
  endfunction

  // Well-formed traffic: after a program/erase/copy the status report
  // usually follows; a few unused or stray opcodes are mixed in as noise.
  task automatic send_random_request();
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] s;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (exp_awaiting && r < 85) op = OP_STATUS;
    else if (r >= 94) op = 3'($urandom_range(0, 7));
    else op = 3'($urandom_range(0, 5));
    a = pick_address();
    s = $urandom;
    if (op == OP_COPY) begin
      s = pick_address();
      if ($urandom_range(0, 99) < 80) s[24] = a[24];
    end
    send_request(op, a, s, 8'($urandom), 1'b0, ST_OK);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, re-rolled every so often; all-ones for stretches
  // ---------------------------------------------------------------------------

  logic [15:0] stall_pattern = 16'hFFFF;
  int          stall_hold = 0;
  int          stall_phase = 0;

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_pattern = ($urandom_range(0, 99) < 35) ? 16'hFFFF
                                                   : 16'($urandom_range(1, 16'hFFFF));
      stall_hold = $urandom_range(20, 200);
    end else begin
      stall_hold--;
    end
    out_ready = stall_pattern[stall_phase];
    stall_phase = (stall_phase + 1) % 16;
  end

  // Scoreboard: each accepted word against the oldest expectation
  // (fields printed as kind/byte/words/code/last)
  always @(posedge clk) begin
    ncs_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected word kind=%0d byte=%02h words=%0d code=%0d last=%0b",
                   $realtime, cycle_kind, bus_byte, burst_words, status_code, last);
      end else begin
        want = pending_words.pop_front();
        if (cycle_kind != want.kind || bus_byte != want.data ||
            burst_words != want.words || status_code != want.code ||
            last != want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch exp %0d/%02h/%0d/%0d/%0b got %0d/%02h/%0d/%0d/%0b",
                     $realtime, want.kind, want.data, want.words, want.code, want.last,
                     cycle_kind, bus_byte, burst_words, status_code, last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = REG_BASE_ADDR;
    pwdata         = 32'h0;
    in_valid       = 1'b0;
    opcode         = OP_READ;
    address        = 32'h0;
    src_address    = 32'h0;
    status_byte    = 8'h00;
    cfg_base       = 32'h0;
    cfg_init       = 1'b0;
    exp_awaiting   = 1'b0;
    mismatch_count = 0;
    burst_left     = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed table; register rows wait for the block to go idle first
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].reg_addr, directed_rows[i].a);
      end else begin
        send_request(directed_rows[i].op, directed_rows[i].a, directed_rows[i].s,
                     directed_rows[i].sb, directed_rows[i].typed, directed_rows[i].code);
      end
    end

    // Random phases, each under its own register setting
    foreach (rand_phases[p]) begin
      wait_idle();
      write_reg(REG_BASE_ADDR, rand_phases[p].rand_base ? 32'($urandom)
                                                        : rand_phases[p].base);
      write_reg(REG_INIT_ADDR, {31'd0, rand_phases[p].init});
      repeat (rand_phases[p].count) send_random_request();
    end

    wait_idle();
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~300 items x 22 words x stalls)
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
